// ----- rtl/dpi_pkg.sv -----
// ----------------------------------------------------------------------------
// Dubins path interpolator package
// Shared types, constants and helper functions for the interpolator.
// ----------------------------------------------------------------------------
package dpi_pkg;

  localparam int FracBits    = 16;
  localparam int CordicSteps = 20;
  localparam int IterW       = $clog2(CordicSteps + 1);

  // Q5.30 angle constants, held in 35 bits.
  localparam logic signed [34:0] Q30Pi     = 35'sd3373259426;
  localparam logic signed [34:0] Q30TwoPi  = 35'sd6746518852;
  localparam logic signed [34:0] Q30HalfPi = 35'sd1686629713;
  localparam logic signed [34:0] Q30Gain   = 35'sd652032874;

  // Reciprocal of the Q30 value of 2*pi, scaled by 2^64.
  localparam logic [31:0] InvTwoPi = 32'd2734261102;

  typedef enum logic [1:0] {
    SEG_S = 2'd0,
    SEG_L = 2'd1,
    SEG_R = 2'd2
  } seg_kind_e;

  typedef enum logic [2:0] {
    REG_PATH    = 3'd0,
    REG_FIRST   = 3'd1,
    REG_MIDDLE  = 3'd2,
    REG_LAST    = 3'd3,
    REG_RADIUS  = 3'd4,
    REG_START_X = 3'd5,
    REG_START_Y = 3'd6,
    REG_HEADING = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEG,
    ST_RED0,
    ST_RED1,
    ST_RED2,
    ST_CORDIC,
    ST_ROUND,
    ST_UPDATE,
    ST_SCALE_X,
    ST_SCALE_Y,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SEG,
    CMD_RED0,
    CMD_RED1,
    CMD_RED2,
    CMD_ITER,
    CMD_ROUND,
    CMD_UPDATE
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e    op;
    logic       second;   // second trig evaluation of an arc
    logic [1:0] scale_sel; // 1: x, 2: y
  } dp_cmd_t;

  typedef struct packed {
    logic more_seg;   // segment to walk now
    logic is_arc;     // current segment is an arc
    logic iter_last;  // last CORDIC iteration
  } dp_stat_t;

  function automatic logic signed [34:0] atan_q30(input logic [4:0] i);
    logic signed [34:0] r;
    unique case (i)
      5'd0: r = 35'sd843314857;
      5'd1: r = 35'sd497837829;
      5'd2: r = 35'sd263043837;
      5'd3: r = 35'sd133525159;
      5'd4: r = 35'sd67021687;
      5'd5: r = 35'sd33543516;
      5'd6: r = 35'sd16775851;
      5'd7: r = 35'sd8388437;
      5'd8: r = 35'sd4194283;
      5'd9: r = 35'sd2097149;
      5'd31: r = 35'sd0;
      default: r = 35'sd1 <<< (5'd30 - i);
    endcase
    return r;
  endfunction

  function automatic seg_kind_e seg_kind(input logic [2:0] pw, input logic [1:0] idx);
    seg_kind_e k;
    unique case (pw)
      3'd1: k = (idx == 2'd1) ? SEG_S : SEG_R;
      3'd2: k = (idx == 2'd0) ? SEG_R : (idx == 2'd1) ? SEG_S : SEG_L;
      3'd3: k = (idx == 2'd0) ? SEG_L : (idx == 2'd1) ? SEG_S : SEG_R;
      3'd4: k = (idx == 2'd1) ? SEG_L : SEG_R;
      3'd5: k = (idx == 2'd1) ? SEG_R : SEG_L;
      default: k = (idx == 2'd1) ? SEG_S : SEG_L;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/dpi_ctrl.sv -----
// ----------------------------------------------------------------------------
// Dubins path interpolator controller
// Sequences segment walk, trig evaluations, scaling and result strobe.
// ----------------------------------------------------------------------------
module dpi_ctrl import dpi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy_o,
  output logic     done_o
);

  state_e state_q, state_d;
  logic   second_q, second_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    second_d  = second_q;
    cmd_o     = '{op: CMD_NONE, second: second_q, scale_sel: 2'd0};
    busy_o    = (state_q != ST_IDLE);
    done_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.op = CMD_LOAD;
          state_d  = ST_SEG;
        end
      end
      ST_SEG: begin
        second_d = 1'b0;
        if (stat_i.more_seg) begin
          cmd_o.op = CMD_SEG;
          state_d  = ST_RED0;
        end else begin
          state_d = ST_SCALE_X;
        end
      end
      ST_RED0: begin
        cmd_o.op = CMD_RED0;
        state_d  = ST_RED1;
      end
      ST_RED1: begin
        cmd_o.op = CMD_RED1;
        state_d  = ST_RED2;
      end
      ST_RED2: begin
        cmd_o.op = CMD_RED2;
        state_d  = ST_CORDIC;
      end
      ST_CORDIC: begin
        cmd_o.op = CMD_ITER;
        if (stat_i.iter_last) state_d = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.op = CMD_ROUND;
        if (stat_i.is_arc && !second_q) begin
          second_d = 1'b1;
          state_d  = ST_RED0;
        end else begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.op = CMD_UPDATE;
        state_d  = ST_SEG;
      end
      ST_SCALE_X: begin
        cmd_o.scale_sel = 2'd1;
        state_d         = ST_SCALE_Y;
      end
      ST_SCALE_Y: begin
        cmd_o.scale_sel = 2'd2;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/dpi_datapath.sv -----
// ----------------------------------------------------------------------------
// Dubins path interpolator datapath
// Segment walk registers, one shared CORDIC rotator, straight-step
// multipliers and the radius scaling with saturation.
// ----------------------------------------------------------------------------
module dpi_datapath import dpi_pkg::*; (
  input  logic               clk_i,
  input  dp_cmd_t            cmd_i,
  input  logic signed [31:0] arc_position_i,
  input  logic [2:0]         path_word_i,
  input  logic [31:0]        first_length_i,
  input  logic [31:0]        middle_length_i,
  input  logic [31:0]        last_length_i,
  input  logic [31:0]        turning_radius_i,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] start_heading_i,
  output dp_stat_t           stat_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] heading_o,
  output logic signed [1:0]  turn_code_o
);

  logic [33:0]        seg_q;      // remaining arc
  logic [1:0]         idx_q;
  logic [31:0]        v_q;        // length walked in the current segment
  seg_kind_e          kind_q;
  logic signed [35:0] phi_q;
  logic signed [35:0] ax_q, ay_q;
  logic signed [1:0]  turn_q;
  logic signed [34:0] z_q;
  logic signed [32:0] cx_q, cy_q;
  logic               neg_q;
  logic [IterW-1:0]   it_q;
  logic signed [32:0] s0_q, c0_q, s1_q, c1_q;
  logic signed [31:0] px_q, py_q;

  logic [33:0] total;
  assign total = {2'b0, first_length_i} + {2'b0, middle_length_i} + {2'b0, last_length_i};

  logic [31:0] cur_len;
  always_comb begin
    unique case (idx_q)
      2'd0:    cur_len = first_length_i;
      2'd1:    cur_len = middle_length_i;
      default: cur_len = last_length_i;
    endcase
  end

  // Trig angle: heading, or heading moved by the arc for the second pass.
  logic signed [35:0] ang;
  always_comb begin
    ang = phi_q;
    if (cmd_i.second) begin
      if (kind_q == SEG_L) ang = phi_q + $signed({4'b0, v_q});
      else                 ang = phi_q - $signed({4'b0, v_q});
    end
  end

  // Reduction step one: quotient estimate of |ang * 2^14| / (2*pi) from the
  // top 32 bits of the magnitude times the reciprocal. The estimate is off by
  // at most one either way, which step three corrects.
  logic signed [49:0] zfull;
  assign zfull = $signed({ang, 14'b0});
  logic [49:0]  zmag;
  logic [63:0]  qprod;
  logic [17:0]  qest;
  assign zmag  = zfull[49] ? 50'(-zfull) : 50'(zfull);
  assign qprod = zmag[49:18] * InvTwoPi;
  assign qest  = qprod[63:46];

  logic [49:0]        zmag_q;
  logic [17:0]        qest_q;
  logic               rneg_q;

  // Reduction step two: remainder against the estimated quotient.
  logic signed [53:0] qsub;
  assign qsub = $signed({1'b0, qest_q}) * $signed({1'b0, Q30TwoPi});

  logic signed [50:0] rem_q;

  // Reduction step three: exact remainder then fold.
  logic signed [50:0] r0;
  logic signed [50:0] r1;
  logic signed [34:0] zr, zf;
  logic               fneg;
  always_comb begin
    r0 = rem_q;
    if (r0 >= 51'(Q30TwoPi)) r0 = r0 - 51'(Q30TwoPi);
    if (r0 >= 51'(Q30TwoPi)) r0 = r0 - 51'(Q30TwoPi);
    if (r0 < 0) r0 = r0 + 51'(Q30TwoPi);
    // r0 is mag mod 2*pi in [0, 2*pi); apply sign like C remainder then wrap.
    if (rneg_q && r0 != 0) r1 = 51'(Q30TwoPi) - r0;
    else                   r1 = r0;
    zr = 35'(r1);
    if (zr > Q30Pi) zr = zr - Q30TwoPi;
    fneg = 1'b0;
    zf   = zr;
    if (zr > Q30HalfPi) begin
      zf   = zr - Q30Pi;
      fneg = 1'b1;
    end else if (zr < -Q30HalfPi) begin
      zf   = zr + Q30Pi;
      fneg = 1'b1;
    end
  end

  // CORDIC iteration.
  logic signed [32:0] dx, dy;
  logic [4:0]         it5;
  assign it5 = 5'(it_q);
  assign dx  = cy_q >>> it5;
  assign dy  = cx_q >>> it5;

  // Rounding to Q16.
  logic signed [32:0] fx, fy, rc, rs;
  assign fx = neg_q ? -cx_q : cx_q;
  assign fy = neg_q ? -cy_q : cy_q;
  assign rc = (fx + 33'sd8192) >>> 14;
  assign rs = (fy + 33'sd8192) >>> 14;

  // Straight step: v * cos and v * sin (33x33 bits, the trig values fit 18).
  logic signed [52:0] mc, ms;
  assign mc = $signed({1'b0, v_q}) * c0_q;
  assign ms = $signed({1'b0, v_q}) * s0_q;

  // Scaling: |unit| * radius >> FracBits, sign restored, start added.
  logic signed [35:0] unit;
  logic signed [31:0] st;
  logic [35:0]        mag;
  logic [67:0]        prod;
  logic [51:0]        p;
  logic signed [53:0] sv;
  logic signed [31:0] sc_out;
  always_comb begin
    unit = (cmd_i.scale_sel == 2'd2) ? ay_q : ax_q;
    st   = (cmd_i.scale_sel == 2'd2) ? start_y_i : start_x_i;
    mag  = unit[35] ? 36'(-unit) : 36'(unit);
    prod = mag * turning_radius_i;
    p    = prod[67:16];
    sv   = unit[35] ? -$signed({2'b0, p}) : $signed({2'b0, p});
    sv   = sv + 54'(st);
    if (sv > 54'sd2147483647)       sc_out = 32'sh7FFFFFFF;
    else if (sv < -54'sd2147483648) sc_out = 32'sh80000000;
    else                            sc_out = sv[31:0];
  end

  assign stat_o.more_seg  = (idx_q != 2'd3) && (seg_q != '0);
  assign stat_o.is_arc    = (kind_q != SEG_S);
  assign stat_o.iter_last = (it_q == IterW'(CordicSteps - 1));

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      CMD_LOAD: begin
        if (arc_position_i[31] || arc_position_i == 0) seg_q <= '0;
        else if ({2'b0, arc_position_i} > total)         seg_q <= total;
        else                                             seg_q <= {2'b0, arc_position_i};
        idx_q  <= 2'd0;
        phi_q  <= 36'(start_heading_i);
        ax_q   <= '0;
        ay_q   <= '0;
        turn_q <= 2'sd0;
      end
      CMD_SEG: begin
        if (seg_q < {2'b0, cur_len}) v_q <= seg_q[31:0];
        else                         v_q <= cur_len;
        kind_q <= seg_kind(path_word_i, idx_q);
      end
      CMD_RED0: begin
        zmag_q <= zmag;
        qest_q <= qest;
        rneg_q <= zfull[49];
      end
      CMD_RED1: begin
        rem_q <= $signed({1'b0, zmag_q}) - 51'(qsub);
      end
      CMD_RED2: begin
        z_q   <= zf;
        neg_q <= fneg;
        cx_q  <= 33'(Q30Gain);
        cy_q  <= '0;
        it_q  <= '0;
      end
      CMD_ITER: begin
        if (!z_q[34]) begin
          cx_q <= cx_q - dx;
          cy_q <= cy_q + dy;
          z_q  <= z_q - atan_q30(it5);
        end else begin
          cx_q <= cx_q + dx;
          cy_q <= cy_q - dy;
          z_q  <= z_q + atan_q30(it5);
        end
        it_q <= it_q + 1'b1;
      end
      CMD_ROUND: begin
        if (cmd_i.second) begin
          s1_q <= rs;
          c1_q <= rc;
        end else begin
          s0_q <= rs;
          c0_q <= rc;
        end
      end
      CMD_UPDATE: begin
        seg_q <= seg_q - {2'b0, v_q};
        idx_q <= idx_q + 2'd1;
        unique case (kind_q)
          SEG_L: begin
            ax_q   <= ax_q + 36'(s1_q - s0_q);
            ay_q   <= ay_q + 36'(c0_q - c1_q);
            phi_q  <= phi_q + $signed({4'b0, v_q});
            turn_q <= 2'sd1;
          end
          SEG_R: begin
            ax_q   <= ax_q + 36'(s0_q - s1_q);
            ay_q   <= ay_q + 36'(c1_q - c0_q);
            phi_q  <= phi_q - $signed({4'b0, v_q});
            turn_q <= -2'sd1;
          end
          default: begin
            ax_q   <= ax_q + 36'(mc >>> 16);
            ay_q   <= ay_q + 36'(ms >>> 16);
            turn_q <= 2'sd0;
          end
        endcase
      end
      default: ;
    endcase
    if (cmd_i.scale_sel == 2'd1) px_q <= sc_out;
    if (cmd_i.scale_sel == 2'd2) py_q <= sc_out;
  end

  assign pos_x_o     = px_q;
  assign pos_y_o     = py_q;
  assign heading_o   = (phi_q > 36'sd2147483647) ? 32'sh7FFFFFFF :
                       (phi_q < -36'sd2147483648) ? 32'sh80000000 : phi_q[31:0];
  assign turn_code_o = turn_q;

endmodule

// ----- rtl/dubins_path_interpolator.sv -----
// Each straight segment walked takes one CORDIC pass and each arc two passes on
// one shared rotator; scaling of x and y and the result strobe follow the walk.
// A new item is taken only while idle; busy stays high until the result strobe.
// Reset clears the controller and loads the register resets.
// ----------------------------------------------------------------------------
// Dubins path interpolator
// Returns the pose at an arc position along a configured Dubins path.
// ----------------------------------------------------------------------------
module dubins_path_interpolator import dpi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] arc_position_i,
  output logic               valid_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] heading_o,
  output logic signed [1:0]  turn_code_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [2:0]  path_word_q;
  logic [31:0] first_q, middle_q, last_q, radius_q, sx_q, sy_q, sh_q;
  reg_idx_e    widx;

  assign pready = 1'b1;
  assign widx   = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_word_q <= '0;
      first_q     <= '0;
      middle_q    <= '0;
      last_q      <= '0;
      radius_q    <= 32'd65536;
      sx_q        <= '0;
      sy_q        <= '0;
      sh_q        <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_PATH:    path_word_q <= pwdata[2:0];
        REG_FIRST:   first_q     <= pwdata;
        REG_MIDDLE:  middle_q    <= pwdata;
        REG_LAST:    last_q      <= pwdata;
        REG_RADIUS:  radius_q    <= pwdata;
        REG_START_X: sx_q        <= pwdata;
        REG_START_Y: sy_q        <= pwdata;
        REG_HEADING: sh_q        <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_PATH:    prdata = {29'b0, path_word_q};
      REG_FIRST:   prdata = first_q;
      REG_MIDDLE:  prdata = middle_q;
      REG_LAST:    prdata = last_q;
      REG_RADIUS:  prdata = radius_q;
      REG_START_X: prdata = sx_q;
      REG_START_Y: prdata = sy_q;
      default:     prdata = sh_q;
    endcase
  end

  dp_cmd_t  cmd;
  dp_stat_t stat;

  dpi_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o),
    .done_o (valid_o)
  );

  dpi_datapath u_dp (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .arc_position_i  (arc_position_i),
    .path_word_i     (path_word_q),
    .first_length_i  (first_q),
    .middle_length_i (middle_q),
    .last_length_i   (last_q),
    .turning_radius_i(radius_q),
    .start_x_i       ($signed(sx_q)),
    .start_y_i       ($signed(sy_q)),
    .start_heading_i ($signed(sh_q)),
    .stat_o          (stat),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o),
    .heading_o       (heading_o),
    .turn_code_o     (turn_code_o)
  );

endmodule

// ----- rtl/dpi_checker.sv -----
// ----------------------------------------------------------------------------
// Dubins path interpolator checker
// Port-level properties of the command interface.
// ----------------------------------------------------------------------------
module dpi_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              valid_o,
  input logic signed [1:0] turn_code_o
);

  // An accepted item makes the block busy.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("busy not raised");

  // The result strobe ends the busy period.
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !busy_o) else $error("busy after result");

  // A result only appears while busy.
  a_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o) else $error("result while idle");

  // The turn code never takes the unused value while a result is shown.
  a_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> turn_code_o != 2'b10) else $error("bad turn code");

endmodule

bind dubins_path_interpolator dpi_checker u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .valid_o    (valid_o),
  .turn_code_o(turn_code_o)
);

// ----- verif/dubins_path_interpolator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dubins path interpolator testbench
// Drives arc positions over several path settings written through the APB
// port, predicts each pose with a local fixed-point model and checks every
// result beat field by field.
// ----------------------------------------------------------------------------
module dubins_path_interpolator_tb import dpi_pkg::*; ();

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 200;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] hd;
    logic signed [1:0]  tc;
  } pose_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic signed [31:0] arc_position_i = '0;
  logic               valid_o;
  logic signed [31:0] pos_x_o, pos_y_o, heading_o;
  logic signed [1:0]  turn_code_o;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  dubins_path_interpolator dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Local copy of the path registers.
  logic [2:0]  path_r;
  logic [31:0] len_r [3];
  logic [31:0] radius_r;
  logic signed [31:0] sx_r, sy_r, shd_r;

  logic signed [31:0] arc_queue [$];
  pose_t              pose_queue [$];
  bit                 failed = 1'b0;
  bit                 quiet = 1'b1;   // no idling while set
  bit                 hold = 1'b0;    // sender paused
  int                 stall_cnt = 0;

  task automatic put_arc(input logic signed [31:0] a);
    arc_queue.insert(arc_queue.size(), a);
  endtask

  function automatic longint fdiv(input longint v, input int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint atan_entry(input int i);
    longint t [10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                       33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return t[i];
    if (i > 30) return 0;
    return 64'sd1 << (30 - i);
  endfunction

  task automatic sin_cos(input longint ang, output longint s, output longint c);
    longint z, x, y, dx, dy;
    bit neg;
    z = ang * (64'sd1 << (30 - FracBits));
    x = 652032874;
    y = 0;
    neg = 1'b0;
    z = z % 64'sd6746518852;
    if (z < 0) z += 64'sd6746518852;
    if (z > 64'sd3373259426) z -= 64'sd6746518852;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426; neg = 1'b1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426; neg = 1'b1;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      dx = fdiv(y, i);
      dy = fdiv(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    if (neg) begin
      x = -x; y = -y;
    end
    c = fdiv(x + (64'sd1 << (29 - FracBits)), 30 - FracBits);
    s = fdiv(y + (64'sd1 << (29 - FracBits)), 30 - FracBits);
  endtask

  function automatic longint scale_to_world(input longint u, input logic signed [31:0] org);
    logic [63:0] m, p;
    longint v;
    m = (u < 0) ? -u : u;
    p = ((m >> 32) * radius_r << (32 - FracBits)) + ((m[31:0] * radius_r) >> FracBits);
    v = (u < 0) ? -longint'(p) : longint'(p);
    return clip32(v + org);
  endfunction

  function automatic seg_kind_e kind_of(input logic [2:0] pw, input int idx);
    seg_kind_e k [6][3] = '{'{SEG_L, SEG_S, SEG_L}, '{SEG_R, SEG_S, SEG_R},
                            '{SEG_R, SEG_S, SEG_L}, '{SEG_L, SEG_S, SEG_R},
                            '{SEG_R, SEG_L, SEG_R}, '{SEG_L, SEG_R, SEG_L}};
    return (pw > 3'd5) ? k[0][idx] : k[pw][idx];
  endfunction

  task automatic predict_pose(input logic signed [31:0] arc, output pose_t r);
    longint unsigned total, rest, v;
    longint phi, ax, ay, s0, c0, s1, c1;
    int turn;
    total = longint'(len_r[0]) + len_r[1] + len_r[2];
    rest = (arc <= 0) ? 0 : longint'(arc);
    if (rest > total) rest = total;
    phi = shd_r;
    ax = 0; ay = 0; turn = 0;
    for (int i = 0; i < 3 && rest > 0; i++) begin
      v = (rest < len_r[i]) ? rest : len_r[i];
      rest -= v;
      sin_cos(phi, s0, c0);
      case (kind_of(path_r, i))
        SEG_L: begin
          sin_cos(phi + longint'(v), s1, c1);
          ax += s1 - s0; ay += c0 - c1; phi += longint'(v); turn = 1;
        end
        SEG_R: begin
          sin_cos(phi - longint'(v), s1, c1);
          ax += s0 - s1; ay += c1 - c0; phi -= longint'(v); turn = -1;
        end
        default: begin
          ax += fdiv(longint'(v) * c0, FracBits);
          ay += fdiv(longint'(v) * s0, FracBits);
          turn = 0;
        end
      endcase
    end
    r.px = 32'(scale_to_world(ax, sx_r));
    r.py = 32'(scale_to_world(ay, sy_r));
    r.hd = 32'(clip32(phi));
    r.tc = 2'(turn);
  endtask

  // Driver: one beat per accepted start, random gaps unless quiet.
  always @(negedge clk_i) begin
    if (start_i && !busy_o && rst_ni) begin
      // the beat was taken at the last rising edge
    end
    if (!hold && arc_queue.size() > 0 && (quiet || $urandom_range(99) >= 28)) begin
      start_i <= 1'b1;
      arc_position_i <= arc_queue[0];
    end else begin
      start_i <= 1'b0;
      arc_position_i <= $urandom;
    end
  end

  // Sender bookkeeping at the accepting edge.
  always @(posedge clk_i) begin
    pose_t p;
    if (rst_ni && start_i && !busy_o) begin
      predict_pose(arc_position_i, p);
      pose_queue.insert(pose_queue.size(), p);
      void'(arc_queue.pop_front());
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    pose_t e;
    if (rst_ni && valid_o) begin
      if (pose_queue.size() == 0) begin
        $error("result beat with nothing expected");
        failed = 1'b1;
      end else begin
        e = pose_queue.pop_front();
        if (pos_x_o !== e.px) begin
          $error("pos_x expected %0d got %0d", e.px, pos_x_o); failed = 1'b1;
        end
        if (pos_y_o !== e.py) begin
          $error("pos_y expected %0d got %0d", e.py, pos_y_o); failed = 1'b1;
        end
        if (heading_o !== e.hd) begin
          $error("heading expected %0d got %0d", e.hd, heading_o); failed = 1'b1;
        end
        if (turn_code_o !== e.tc) begin
          $error("turn_code expected %0d got %0d", e.tc, turn_code_o); failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat, result or register access.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o || psel) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > WatchdogLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic reg_write(input reg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 5'(idx) << 2; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_PATH:    path_r = val[2:0];
      REG_FIRST:   len_r[0] = val;
      REG_MIDDLE:  len_r[1] = val;
      REG_LAST:    len_r[2] = val;
      REG_RADIUS:  radius_r = val;
      REG_START_X: sx_r = val;
      REG_START_Y: sy_r = val;
      default:     shd_r = val;
    endcase
  endtask

  task automatic drain;
    while (arc_queue.size() > 0 || pose_queue.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic random_setting(input logic [2:0] pw, input bit wide);
    reg_write(REG_PATH, {29'b0, pw});
    for (int i = 0; i < 3; i++)
      reg_write(reg_idx_e'(REG_FIRST + i),
                wide ? $urandom : ($urandom_range(3) == 0 ? 0 : $urandom_range(32'h0004_0000)));
    reg_write(REG_RADIUS, wide ? $urandom : $urandom_range(32'h0010_0000));
    reg_write(REG_START_X, wide ? $urandom : $urandom_range(32'h0100_0000) - 32'h0080_0000);
    reg_write(REG_START_Y, $urandom);
    reg_write(REG_HEADING, $urandom_range(3) == 0 ? $urandom
                                               : $urandom_range(32'h0008_0000) - 32'h0004_0000);
  endtask

  function automatic logic [31:0] path_total;
    longint unsigned t;
    t = longint'(len_r[0]) + len_r[1] + len_r[2];
    return (t > 32'h7fff_ffff) ? 32'h7fff_ffff : t[31:0];
  endfunction

  initial begin
    path_r = 3'd0; len_r = '{0, 0, 0}; radius_r = 32'h0001_0000;
    sx_r = 0; sy_r = 0; shd_r = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed: reset registers, then each path word with edge arc values.
    put_arc(32'sh7fff_ffff);
    put_arc(32'sh8000_0000);
    drain();
    for (int pw = 0; pw < 8; pw++) begin
      reg_write(REG_PATH, pw);
      reg_write(REG_FIRST, 32'h0001_8000);
      reg_write(REG_MIDDLE, (pw == 7) ? 32'h0 : 32'h0002_0000);
      reg_write(REG_LAST, 32'h0001_0000);
      put_arc(0);
      put_arc(32'h0001_0000);
      put_arc(32'h0002_4000);
      put_arc(32'sh7fff_ffff);
      drain();
    end
    // Zero radius, extreme lengths and start point.
    reg_write(REG_RADIUS, 0);
    reg_write(REG_START_X, 32'h8000_0000);
    reg_write(REG_START_Y, 32'h7fff_ffff);
    reg_write(REG_HEADING, 32'h8000_0000);
    put_arc(32'h0003_0000);
    drain();
    reg_write(REG_RADIUS, 32'hffff_ffff);
    reg_write(REG_FIRST, 32'hffff_ffff);
    reg_write(REG_MIDDLE, 32'hffff_ffff);
    reg_write(REG_LAST, 32'hffff_ffff);
    reg_write(REG_HEADING, 32'h7fff_ffff);
    put_arc(32'sh7fff_ffff);
    put_arc(32'h0000_0001);
    drain();

    // Random phases; mostly positions on the path, some anywhere.
    quiet = 1'b1;
    for (int ph = 0; ph < 20; ph++) begin
      random_setting(3'($urandom_range(7)), ph % 5 == 4);
      for (int n = 0; n < 100; n++)
        put_arc(($urandom_range(9) == 0) ? $urandom : $urandom_range(path_total()));
      if (ph == 10) begin
        // Part-way through, hold the sender until every pose is back.
        while (arc_queue.size() > 50) @(posedge clk_i);
        hold = 1'b1;
        @(negedge clk_i);
        while (pose_queue.size() > 0) @(posedge clk_i);
        @(negedge clk_i) hold = 1'b0;
      end
      drain();
      quiet = (ph == 0);
    end

    if (!failed) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
